>>> rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, codes, state encoding and control types of the banded
// triangular solver.
// ----------------------------------------------------------------------------
package bts_pkg;

   // default storage sizes
   localparam int MAX_SIZE_DEF = 1024;
   localparam int MAX_BAND_DEF = 8;

   // field widths
   localparam int IDX_W      = 10;
   localparam int ROW_W      = 4;
   localparam int VAL_W      = 32;
   localparam int BW_W       = 4;
   localparam int SS_W       = 11;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int QUO_W      = 32;
   localparam int FRAC_W     = 16;

   localparam logic [SS_W-1:0] SS_RESET = 11'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE   = 2'd2;

   // operations
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_SOLVE = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_ZERO_DIAG = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SAT       = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MOD,
      ST_SEEK,
      ST_MAC,
      ST_DIAG,
      ST_DIAGW,
      ST_CHECK,
      ST_DIV,
      ST_FIN,
      ST_WSEEK,
      ST_DONE
   } state_type;

   // control of one window cell
   typedef struct packed {
      logic rot;
      logic wr;
   } cell_ctl_type;

endpackage

>>> rtl/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/bts_cell.sv
// ----------------------------------------------------------------------------
// bts_cell
// One slot of the solution window ring. Takes its neighbour's word when the
// ring rotates, or a new solution when written.
// ----------------------------------------------------------------------------
module bts_cell
   import bts_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [WIDTH-1:0] shift_in,
   input  logic [WIDTH-1:0] load_value,
   output logic [WIDTH-1:0] value
);

   logic [WIDTH-1:0] value_ff;
   logic [WIDTH-1:0] value_in;

   // rotate beats write
   always_comb begin
      if (ctl.rot) begin
         value_in = shift_in;
      end else if (ctl.wr) begin
         value_in = load_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> rtl/bts_div.sv
// ----------------------------------------------------------------------------
// bts_div
// Restoring divider, one quotient bit a cycle: (dividend * 2^16) / divisor.
// Caller guarantees the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module bts_div
   import bts_pkg::*;
#(
   parameter int NUM_W = 53
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int DW    = NUM_W + FRAC_W;
   localparam int CNT_W = $clog2(QUO_W);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // one compare and subtract per step
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {dividend, {FRAC_W{1'b0}}};
         den_in  = DW'(divisor) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = CNT_W'(QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/banded_triangular_solver_top.sv
// ----------------------------------------------------------------------------
// banded_triangular_solver_top
// Banded triangular solver, Q16.16, compact column storage, window ring.
// A load word is written straight into the coefficient store; the next word can follow
// at once. A solve word reads its n band terms while rotating the window ring, reads the
// diagonal, checks for a zero diagonal or a saturated quotient, runs the 32-step serial
// divider unless one of those is found, then rotates the ring to the row's slot and writes
// the solution there before raising its response. One word at a time: the request stall
// drops in the same cycle as the response is raised, later if held off.
// Synchronous reset: registers return to 0, 1024, 0; stores are not cleared.
// ----------------------------------------------------------------------------
module banded_triangular_solver_top
   import bts_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF,
   parameter int MAX_BAND = MAX_BAND_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // request words
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [IDX_W-1:0]        req_index,
   input  logic [ROW_W-1:0]        req_band_row,
   input  logic signed [VAL_W-1:0] req_value,
   // response words
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_result_index,
   output logic signed [VAL_W-1:0] rsp_solution,
   output logic [STAT_W-1:0]       rsp_status,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int ROWS   = MAX_BAND + 1;
   localparam int DEPTH  = MAX_SIZE * ROWS;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = (MAX_BAND > 1) ? $clog2(MAX_BAND) : 1;
   localparam int PROD_W = 2 * VAL_W - FRAC_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_BAND + 1);
   localparam int NUM_W  = ACC_W + 1;
   localparam int DW     = NUM_W + FRAC_W;
   localparam int MOD_S  = IDX_W + $clog2(MAX_BAND);
   localparam int MOD_R  = ((1 << MOD_S) + MAX_BAND - 1) / MAX_BAND;

   state_type state_ff, state_in;

   logic [BW_W-1:0]  bw_ff;
   logic [SS_W-1:0]  ss_ff;
   logic             tm_ff;

   logic [IDX_W-1:0]        i_ff;
   logic signed [VAL_W-1:0] b_ff;
   logic [BW_W-1:0]         n_ff, cnt_ff;
   logic [AW-1:0]           addr_ff, diag_addr_ff;
   logic [SW-1:0]           mod_ff, head_ff;
   logic                    v1_ff, v2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [NUM_W-1:0]  num_ff;
   logic signed [VAL_W-1:0]  d_ff;
   logic [NUM_W-1:0]         an_ff;
   logic                     nneg_ff, sgn_ff, sat_ff;
   logic signed [VAL_W-1:0]  sol_ff;
   logic [STAT_W-1:0]        stat_ff;

   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic signed [VAL_W-1:0] rsp_sol_ff;
   logic [STAT_W-1:0]       rsp_stat_ff;

   logic             accept, load_we, solve_ok;
   logic [BW_W-1:0]  q_val;
   logic [11:0]      p12;
   logic [AW-1:0]    load_addr, raddr;
   logic [VAL_W-1:0] rdata;
   logic             issue, rot, wr, div_start, div_done, mac_done, rsp_free;
   logic [QUO_W-1:0] quotient;
   logic [SW-1:0]    start_slot;
   logic [VAL_W-1:0] cell_val [MAX_BAND];
   logic [VAL_W-1:0] ad;
   logic             sat_chk;

   // handshakes
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // clamped band width and size
   assign q_val = (int'(bw_ff) > MAX_BAND) ? BW_W'(MAX_BAND) : bw_ff;
   assign p12   = (int'(ss_ff) < MAX_SIZE) ? 12'(ss_ff) : 12'(MAX_SIZE);
   assign solve_ok = (12'(req_index) < p12);

   // coefficient loads
   assign load_we = accept && (req_operation == OP_LOAD) &&
                    (int'(req_index) < MAX_SIZE) && (int'(req_band_row) <= MAX_BAND);
   assign load_addr = AW'(32'(req_index) * 32'(ROWS) + 32'(req_band_row));

   assign raddr = issue ? addr_ff : diag_addr_ff;

   bts_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_coef_ram (
      .clock (clock),
      .we    (load_we),
      .waddr (load_addr),
      .wdata (req_value),
      .raddr (raddr),
      .rdata (rdata)
   );

   // window ring; cell 0 is the head
   for (genvar k = 0; k < MAX_BAND; k++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.rot = rot;
      assign ctl.wr  = (k == 0) ? wr : 1'b0;
      bts_cell #(
         .WIDTH (VAL_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .shift_in   (cell_val[(k + 1) % MAX_BAND]),
         .load_value (sol_ff),
         .value      (cell_val[k])
      );
   end

   // slot of the first neighbour
   always_comb begin
      logic [SW:0] s_ext, n_ext, t;
      s_ext = {1'b0, mod_ff};
      n_ext = (SW + 1)'(n_ff);
      if (tm_ff) begin
         t = (s_ext >= n_ext) ? (s_ext - n_ext) : (s_ext + (SW + 1)'(MAX_BAND) - n_ext);
      end else begin
         t = s_ext + 1'b1;
         if (t >= (SW + 1)'(MAX_BAND)) begin
            t = '0;
         end
      end
      start_slot = t[SW-1:0];
   end

   assign mac_done = (cnt_ff == n_ff) && !v1_ff && !v2_ff;

   // divisor magnitude and saturation test
   assign ad      = d_ff[VAL_W-1] ? VAL_W'(-d_ff) : VAL_W'(d_ff);
   assign sat_chk = (DW'(an_ff) >= (DW'(ad) << FRAC_W));

   bts_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (an_ff),
      .divisor  (ad),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_SOLVE) && solve_ok) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:  state_in = ST_MOD;
         ST_MOD:   state_in = ST_SEEK;
         ST_SEEK: begin
            if (head_ff == start_slot) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_DIAG;
            end
         end
         ST_DIAG:  state_in = ST_DIAGW;
         ST_DIAGW: state_in = ST_CHECK;
         ST_CHECK: begin
            if (d_ff == '0) begin
               state_in = ST_WSEEK;
            end else if (sat_chk) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:   state_in = ST_WSEEK;
         ST_WSEEK: begin
            if (head_ff == mod_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      issue     = 1'b0;
      rot       = 1'b0;
      wr        = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_SEEK:  rot = (head_ff != start_slot);
         ST_MAC: begin
            issue = (cnt_ff != n_ff);
            rot   = v1_ff;
         end
         ST_CHECK: div_start = (d_ff != '0) && !sat_chk;
         ST_WSEEK: begin
            rot = (head_ff != mod_ff);
            wr  = (head_ff == mod_ff);
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bw_ff        <= '0;
         ss_ff        <= SS_RESET;
         tm_ff        <= 1'b0;
         head_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         if (rot) begin
            head_ff <= (int'(head_ff) == MAX_BAND - 1) ? '0 : head_ff + 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BAND_WIDTH:  bw_ff <= csr_data[BW_W-1:0];
               CSR_SYSTEM_SIZE: ss_ff <= csr_data[SS_W-1:0];
               CSR_TRANSPOSE:   tm_ff <= csr_data[0];
               default:         tm_ff <= tm_ff;
            endcase
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      logic [31:0] base;
      logic [11:0] i12, q12;
      logic [63:0] prod_full;
      logic [QUO_W-1:0] qv;
      logic [31:0] mod_quo;
      base = 32'(i_ff) * 32'(ROWS);
      i12  = 12'(i_ff);
      q12  = 12'(q_val);
      prod_full = 64'($signed(rdata) * $signed(cell_val[0]));
      qv   = sat_ff ? '0 : quotient;
      // index over window size by reciprocal multiply
      mod_quo = (32'(i_ff) * 32'(MOD_R)) >> MOD_S;

      if (accept) begin
         i_ff <= req_index;
         b_ff <= req_value;
      end

      case (state_ff)
         ST_PREP: begin
            acc_ff  <= '0;
            cnt_ff  <= '0;
            mod_ff  <= '0;
            diag_addr_ff <= AW'(base + 32'(q_val));
            if (tm_ff) begin
               if (i12 >= q12) begin
                  n_ff    <= q_val;
                  addr_ff <= AW'(base);
               end else begin
                  n_ff    <= BW_W'(i_ff);
                  addr_ff <= AW'(base + 32'(q_val) - 32'(i_ff));
               end
            end else begin
               if (i12 + q12 < p12 - 1'b1) begin
                  n_ff <= q_val;
               end else begin
                  n_ff <= BW_W'(p12 - 1'b1 - i12);
               end
               addr_ff <= AW'(base + 32'(ROWS) + 32'(q_val) - 32'd1);
            end
         end
         ST_MOD: begin
            mod_ff <= SW'(32'(i_ff) - mod_quo * 32'(MAX_BAND));
         end
         ST_DIAG: begin
            num_ff <= NUM_W'(b_ff) - NUM_W'(acc_ff);
         end
         ST_DIAGW: begin
            d_ff    <= rdata;
            nneg_ff <= num_ff[NUM_W-1];
            an_ff   <= num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
         end
         ST_CHECK: begin
            sgn_ff <= nneg_ff ^ d_ff[VAL_W-1];
            sat_ff <= sat_chk;
            if (d_ff == '0) begin
               sol_ff  <= '0;
               stat_ff <= STAT_ZERO_DIAG;
            end
         end
         ST_FIN: begin
            if (!sgn_ff) begin
               if (sat_ff || qv > 32'h7FFF_FFFF) begin
                  sol_ff  <= 32'sh7FFF_FFFF;
                  stat_ff <= STAT_SAT;
               end else begin
                  sol_ff  <= qv;
                  stat_ff <= STAT_OK;
               end
            end else begin
               if (sat_ff || qv > 32'h8000_0000) begin
                  sol_ff  <= 32'sh8000_0000;
                  stat_ff <= STAT_SAT;
               end else begin
                  sol_ff  <= VAL_W'(-qv);
                  stat_ff <= STAT_OK;
               end
            end
         end
         default: begin
            sol_ff <= sol_ff;
         end
      endcase

      // band product pipeline: read, multiply, accumulate
      if (issue) begin
         cnt_ff  <= cnt_ff + 1'b1;
         addr_ff <= tm_ff ? addr_ff + 1'b1 : addr_ff + AW'(ROWS - 1);
      end
      if (v1_ff) begin
         prod_ff <= prod_full[63:FRAC_W];
      end
      if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end

      // response register
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_idx_ff  <= i_ff;
         rsp_sol_ff  <= sol_ff;
         rsp_stat_ff <= stat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_solution     = rsp_sol_ff;
   assign rsp_status       = rsp_stat_ff;

endmodule
